// ===== hw/rtl/charge_comparison_psd_unit_defines.svh =====
// Assertion macros shared by the charge-comparison PSD unit.
// Depends on nothing; included by the files that carry assertions.
`ifndef CHARGE_COMPARISON_PSD_UNIT_DEFINES_SVH
`define CHARGE_COMPARISON_PSD_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCPSD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CCPSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ccpsd_pkg.sv =====
// Package for the charge-comparison PSD unit: field widths, limits, codes and types.
// Depends on nothing; used by the interfaces and all modules of the block.
`default_nettype none

package ccpsd_pkg;

    localparam int LEN_W     = 12;
    localparam int AMP_W     = 15;
    localparam int POS_W     = 13;
    localparam int END_W     = 14;
    localparam int SUM_W     = 28;
    localparam int RATIO_W   = 17;
    localparam int CNT_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 15;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Saturation magnitudes of the ratio on its positive and negative side.
    localparam int RATIO_POS_LIMIT = 65535;
    localparam int RATIO_NEG_LIMIT = 65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIXED_ANCHOR = 3'd0,
        CFG_PRE_GATE     = 3'd1,
        CFG_SHORT_GATE   = 3'd2,
        CFG_LONG_GATE    = 3'd3,
        CFG_AMP_CUTOFF   = 3'd4
    } ccpsd_cfg_reg_t;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_PREP,
        ST_DIVIDE,
        ST_EMIT
    } ccpsd_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ccpsd_sample_if.sv =====
// Input channel of the charge-comparison PSD unit: one sample word per handshake.
// Depends on ccpsd_pkg for the field widths.
`default_nettype none

interface ccpsd_sample_if
    import ccpsd_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
);
    logic                    valid;
    logic                    ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                    last_sample;
    logic                    use_explicit_start;
    logic [LEN_W-1:0]        explicit_start;
    logic [AMP_W-1:0]        event_amplitude;

    modport source (
        output valid, sample, last_sample, use_explicit_start, explicit_start,
               event_amplitude,
        input  ready
    );

    modport sink (
        input  valid, sample, last_sample, use_explicit_start, explicit_start,
               event_amplitude,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/ccpsd_result_if.sv =====
// Output channel of the charge-comparison PSD unit: one result word per record.
// Depends on ccpsd_pkg for the field widths.
`default_nettype none

interface ccpsd_result_if
    import ccpsd_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   pulse_start;
    logic signed [END_W-1:0]   short_gate_end;
    logic signed [END_W-1:0]   long_gate_end;
    logic signed [SUM_W-1:0]   charge_short;
    logic signed [SUM_W-1:0]   charge_long;
    logic signed [RATIO_W-1:0] psd_ratio;
    logic                      candidate;
    logic [CNT_W-1:0]          total_events;
    logic [CNT_W-1:0]          candidate_events;

    modport source (
        output valid, pulse_start, short_gate_end, long_gate_end, charge_short,
               charge_long, psd_ratio, candidate, total_events, candidate_events,
        input  ready
    );

    modport sink (
        input  valid, pulse_start, short_gate_end, long_gate_end, charge_short,
               charge_long, psd_ratio, candidate, total_events, candidate_events,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/ccpsd_cfg_if.sv =====
// Configuration write channel of the charge-comparison PSD unit.
// Depends on ccpsd_pkg for the index and data widths.
`default_nettype none

interface ccpsd_cfg_if
    import ccpsd_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/ccpsd_divider.sv =====
// Restoring divider of the charge-comparison PSD unit, one quotient bit per cycle.
// Depends on ccpsd_pkg only through the common import.
`default_nettype none

module ccpsd_divider
    import ccpsd_pkg::*;
#(
    parameter int NUM_W = 45,
    parameter int DEN_W = 28
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [NUM_W-1:0]  quot_reg;
    logic [NUM_W-1:0]  quot_next;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  den_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    trial_sub;
    logic              fits;

    // The quotient register starts as the numerator: its top bit is shifted into
    // the partial remainder and the new quotient bit enters from the bottom.
    assign trial     = {rem_reg, quot_reg[NUM_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign fits      = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(NUM_W - 1);
            quot_next = numer;
            rem_next  = '0;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[NUM_W-2:0], fits};
            rem_next  = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/charge_comparison_psd_unit.sv =====
// Charge-comparison PSD unit: gate sums per record and a (long-short)/long ratio.
// Depends on ccpsd_pkg, the three channel interfaces, ccpsd_divider and the defines header.
// Throughput: one sample word per cycle within a record; after the last sample the input
// stalls while the ratio is prepared and divided, longer while a result word waits.
// After the last sample the record passes the prepare, divide and emit states to the output.
// Reset (rst_n, async, active low) clears config, sums, counters, output valid and the FSM.
`default_nettype none
`include "charge_comparison_psd_unit_defines.svh"

module charge_comparison_psd_unit
    import ccpsd_pkg::*;
#(
    parameter int MAX_RECORD      = 4096,
    parameter int SAMPLE_BITS     = 16,
    parameter int RATIO_FRAC_BITS = 15
)
(
    input  logic           clk,
    input  logic           rst_n,
    ccpsd_sample_if.sink   samples,
    ccpsd_result_if.source results,
    ccpsd_cfg_if.sink      cfg
);

    // The sample index holds at MAX_RECORD, so it needs room for that value.
    localparam int IDX_W = $clog2(MAX_RECORD + 1);
    // Gate comparisons are done signed, wide enough for both the index and the ends.
    localparam int CMP_W = (IDX_W + 1 > END_W) ? IDX_W + 1 : END_W;
    // Numerator: |long - short| scaled by the fraction bits, plus half the divisor
    // for round-to-nearest; one extra bit absorbs the rounding carry.
    localparam int DIFF_W = SUM_W + 1;
    localparam int NUM_W  = DIFF_W + RATIO_FRAC_BITS + 1;

    // ------------------------------------------------------------------
    // Configuration registers. The channel never stalls; writes to an
    // index outside the register list are accepted and dropped.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] fixed_anchor_reg;
    logic [LEN_W-1:0] pre_gate_reg;
    logic [LEN_W-1:0] short_gate_reg;
    logic [LEN_W-1:0] long_gate_reg;
    logic [AMP_W-1:0] amp_cutoff_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_anchor_reg <= '0;
            pre_gate_reg     <= '0;
            short_gate_reg   <= '0;
            long_gate_reg    <= '0;
            amp_cutoff_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_FIXED_ANCHOR: fixed_anchor_reg <= cfg.data[LEN_W-1:0];
                CFG_PRE_GATE:     pre_gate_reg     <= cfg.data[LEN_W-1:0];
                CFG_SHORT_GATE:   short_gate_reg   <= cfg.data[LEN_W-1:0];
                CFG_LONG_GATE:    long_gate_reg    <= cfg.data[LEN_W-1:0];
                CFG_AMP_CUTOFF:   amp_cutoff_reg   <= cfg.data[AMP_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Record state and control.
    // ------------------------------------------------------------------
    ccpsd_state_t               state_reg;
    ccpsd_state_t               state_next;
    logic [IDX_W-1:0]           sample_index_reg;
    logic [IDX_W-1:0]           sample_index_next;
    logic signed [POS_W-1:0]    gate_start_reg;
    logic signed [POS_W-1:0]    gate_start_next;
    logic signed [SUM_W-1:0]    short_sum_reg;
    logic signed [SUM_W-1:0]    short_sum_next;
    logic signed [SUM_W-1:0]    long_sum_reg;
    logic signed [SUM_W-1:0]    long_sum_next;
    logic [CNT_W-1:0]           record_count_reg;
    logic [CNT_W-1:0]           record_count_next;
    logic [CNT_W-1:0]           passing_count_reg;
    logic [CNT_W-1:0]           passing_count_next;
    logic                       candidate_reg;
    logic                       candidate_next;
    logic                       ratio_neg_reg;
    logic                       ratio_neg_next;
    logic                       ratio_zero_reg;
    logic                       ratio_zero_next;

    // Output register: the result word waits here while the block goes on
    // accepting the samples of the next record.
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [POS_W-1:0]    out_pulse_start_reg;
    logic signed [END_W-1:0]    out_short_end_reg;
    logic signed [END_W-1:0]    out_long_end_reg;
    logic signed [SUM_W-1:0]    out_charge_short_reg;
    logic signed [SUM_W-1:0]    out_charge_long_reg;
    logic signed [RATIO_W-1:0]  out_ratio_reg;
    logic                       out_candidate_reg;
    logic [CNT_W-1:0]           out_total_reg;
    logic [CNT_W-1:0]           out_passing_reg;
    logic                       out_load;

    logic                       sample_accept;
    logic signed [SAMPLE_BITS-1:0] sample_val;
    logic                       first_sample;
    logic [LEN_W-1:0]           anchor;
    logic signed [POS_W-1:0]    gate_start_cur;
    logic signed [END_W-1:0]    short_end_cur;
    logic signed [END_W-1:0]    long_end_cur;
    logic signed [CMP_W-1:0]    idx_cmp;
    logic                       in_record;
    logic                       in_long;
    logic                       in_short;
    logic signed [SUM_W-1:0]    short_base;
    logic signed [SUM_W-1:0]    long_base;
    logic signed [SUM_W:0]      short_raw;
    logic signed [SUM_W:0]      long_raw;
    logic signed [SUM_W-1:0]    short_sat;
    logic signed [SUM_W-1:0]    long_sat;

    logic signed [DIFF_W-1:0]   ratio_diff;
    logic [DIFF_W-1:0]          diff_mag;
    logic [SUM_W-1:0]           long_mag;
    logic [NUM_W-1:0]           div_numer;
    logic                       div_start;
    logic                       div_done;
    logic [NUM_W-1:0]           div_quot;
    logic signed [RATIO_W-1:0]  ratio_value;

    assign samples.ready = (state_reg == ST_ACCUM);
    assign sample_accept = samples.valid && samples.ready;
    // The sample is a SAMPLE_BITS-wide two's complement value.
    assign sample_val    = samples.sample;

    // The gate start is fixed on the record's first sample and held for the
    // rest of it; the gate lengths are taken from the registers as they stand.
    assign first_sample   = (sample_index_reg == '0);
    assign anchor         = samples.use_explicit_start ? samples.explicit_start
                                                       : fixed_anchor_reg;
    assign gate_start_cur = first_sample
                          ? ($signed({1'b0, anchor}) - $signed({1'b0, pre_gate_reg}))
                          : gate_start_reg;
    assign short_end_cur  = END_W'(gate_start_cur) + $signed({2'b00, short_gate_reg});
    assign long_end_cur   = END_W'(gate_start_cur) + $signed({2'b00, long_gate_reg});

    assign idx_cmp   = $signed({{(CMP_W-IDX_W){1'b0}}, sample_index_reg});
    assign in_record = (sample_index_reg != IDX_W'(MAX_RECORD));
    // A short gate longer than the long gate is bounded by the long gate.
    assign in_long   = in_record
                    && (idx_cmp >= CMP_W'(gate_start_cur))
                    && (idx_cmp < CMP_W'(long_end_cur));
    assign in_short  = in_long && (idx_cmp < CMP_W'(short_end_cur));

    // Sums restart from zero on the first sample of every record.
    assign short_base = first_sample ? '0 : short_sum_reg;
    assign long_base  = first_sample ? '0 : long_sum_reg;
    assign short_raw  = (SUM_W+1)'(short_base) + (SUM_W+1)'(sample_val);
    assign long_raw   = (SUM_W+1)'(long_base) + (SUM_W+1)'(sample_val);

    // Saturate when the two top bits of the one-bit-wider sum disagree.
    always_comb
    begin
        if (short_raw[SUM_W] != short_raw[SUM_W-1])
        begin
            short_sat = short_raw[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            short_sat = short_raw[SUM_W-1:0];
        end
        if (long_raw[SUM_W] != long_raw[SUM_W-1])
        begin
            long_sat = long_raw[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            long_sat = long_raw[SUM_W-1:0];
        end
    end

    // Divider operands, formed from the held sums in the preparation cycle.
    assign ratio_diff = (DIFF_W)'(long_sum_reg) - (DIFF_W)'(short_sum_reg);
    assign diff_mag   = ratio_diff[DIFF_W-1] ? DIFF_W'(-ratio_diff) : DIFF_W'(ratio_diff);
    assign long_mag   = long_sum_reg[SUM_W-1] ? SUM_W'(-long_sum_reg) : SUM_W'(long_sum_reg);
    assign div_numer  = (NUM_W'(diff_mag) << RATIO_FRAC_BITS) + NUM_W'(long_mag >> 1);
    assign div_start  = (state_reg == ST_PREP);

    ccpsd_divider #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (long_mag),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Apply the sign and saturate the magnitude; a zero long charge gives zero.
    always_comb
    begin
        if (ratio_zero_reg)
        begin
            ratio_value = '0;
        end
        else if (ratio_neg_reg)
        begin
            if (div_quot > NUM_W'(RATIO_NEG_LIMIT))
            begin
                ratio_value = RATIO_W'(-RATIO_NEG_LIMIT);
            end
            else
            begin
                ratio_value = -$signed(div_quot[RATIO_W-1:0]);
            end
        end
        else
        begin
            if (div_quot > NUM_W'(RATIO_POS_LIMIT))
            begin
                ratio_value = RATIO_W'(RATIO_POS_LIMIT);
            end
            else
            begin
                ratio_value = $signed(div_quot[RATIO_W-1:0]);
            end
        end
    end

    // Sequencer: accumulate samples, then prepare and run the division once
    // per record, then hand the result word to the output register.
    always_comb
    begin
        state_next         = state_reg;
        sample_index_next  = sample_index_reg;
        gate_start_next    = gate_start_reg;
        short_sum_next     = short_sum_reg;
        long_sum_next      = long_sum_reg;
        record_count_next  = record_count_reg;
        passing_count_next = passing_count_reg;
        candidate_next     = candidate_reg;
        ratio_neg_next     = ratio_neg_reg;
        ratio_zero_next    = ratio_zero_reg;
        out_load           = 1'b0;

        unique case (state_reg)
            ST_ACCUM:
            begin
                if (sample_accept)
                begin
                    gate_start_next = gate_start_cur;
                    short_sum_next  = in_short ? short_sat : short_base;
                    long_sum_next   = in_long ? long_sat : long_base;
                    if (samples.last_sample)
                    begin
                        // The sums stay held until the result word is loaded;
                        // the next record's first sample starts them afresh.
                        sample_index_next = '0;
                        candidate_next    = samples.event_amplitude > amp_cutoff_reg;
                        record_count_next = record_count_reg + CNT_W'(1);
                        if (samples.event_amplitude > amp_cutoff_reg)
                        begin
                            passing_count_next = passing_count_reg + CNT_W'(1);
                        end
                        state_next = ST_PREP;
                    end
                    else if (in_record)
                    begin
                        sample_index_next = sample_index_reg + IDX_W'(1);
                    end
                end
            end
            ST_PREP:
            begin
                ratio_neg_next  = ratio_diff[DIFF_W-1] != long_sum_reg[SUM_W-1];
                ratio_zero_next = (long_sum_reg == '0);
                state_next      = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_ACCUM;
            sample_index_reg  <= '0;
            gate_start_reg    <= '0;
            short_sum_reg     <= '0;
            long_sum_reg      <= '0;
            record_count_reg  <= '0;
            passing_count_reg <= '0;
            candidate_reg     <= 1'b0;
            ratio_neg_reg     <= 1'b0;
            ratio_zero_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            sample_index_reg  <= sample_index_next;
            gate_start_reg    <= gate_start_next;
            short_sum_reg     <= short_sum_next;
            long_sum_reg      <= long_sum_next;
            record_count_reg  <= record_count_next;
            passing_count_reg <= passing_count_next;
            candidate_reg     <= candidate_next;
            ratio_neg_reg     <= ratio_neg_next;
            ratio_zero_reg    <= ratio_zero_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Gate ends are rebuilt from the held start; the user must not change configuration
    // while a record's result is still on its way, as the block itself does not enforce it.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pulse_start_reg  <= gate_start_reg;
            out_short_end_reg    <= END_W'(gate_start_reg) + $signed({2'b00, short_gate_reg});
            out_long_end_reg     <= END_W'(gate_start_reg) + $signed({2'b00, long_gate_reg});
            out_charge_short_reg <= short_sum_reg;
            out_charge_long_reg  <= long_sum_reg;
            out_ratio_reg        <= ratio_value;
            out_candidate_reg    <= candidate_reg;
            out_total_reg        <= record_count_reg;
            out_passing_reg      <= passing_count_reg;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.pulse_start      = out_pulse_start_reg;
    assign results.short_gate_end   = out_short_end_reg;
    assign results.long_gate_end    = out_long_end_reg;
    assign results.charge_short     = out_charge_short_reg;
    assign results.charge_long      = out_charge_long_reg;
    assign results.psd_ratio        = out_ratio_reg;
    assign results.candidate        = out_candidate_reg;
    assign results.total_events     = out_total_reg;
    assign results.candidate_events = out_passing_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A record's last sample always hands over to the divider sequence.
    `CCPSD_ASSERT_NEXT(a_last_starts_prep, clk, rst_n, sample_accept && samples.last_sample, state_reg == ST_PREP, "last sample did not start the ratio sequence")
    // Every record closed bumps the event count by exactly one.
    `CCPSD_ASSERT_NEXT(a_record_count_step, clk, rst_n, sample_accept && samples.last_sample, record_count_reg == ($past(record_count_reg) + CNT_W'(1)), "event count did not advance by one")
    // The divider only finishes while the sequencer waits for it.
    `CCPSD_ASSERT_IMPLIES(a_done_in_divide, clk, rst_n, div_done, state_reg == ST_DIVIDE, "divider finished outside the divide state")
    // No new result word is loaded over one that has not been taken.
    `CCPSD_ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, out_load && out_valid_reg, results.ready, "result word overwritten before it was taken")

endmodule

`default_nettype wire
